// ===== hdl/htwd_pkg.sv =====
// Shared types, constants and helper functions of the table-walk decoder.
`default_nettype none

package htwd_pkg;

    // Node table geometry.
    localparam int NODE_DEPTH = 512;
    localparam int ADDR_W     = $clog2(NODE_DEPTH);

    // Fixed field widths.
    localparam int IDX_W   = 9;
    localparam int SYM_W   = 8;
    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 32;
    localparam int CMD_W   = 2;
    localparam int BIT_W   = $clog2(BYTE_W);

    // Input word kinds carried on the input tuser.
    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_START = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DATA  = 2'd2;

    // One table entry; right child sits in the lowest bits.
    typedef struct packed {
        logic             leaf;
        logic [SYM_W-1:0] value;
        logic [IDX_W-1:0] left;
        logic [IDX_W-1:0] right;
    } node_t;

    localparam int NODE_W = $bits(node_t);

    // Input tdata layout, node_index in the lowest bits.
    typedef struct packed {
        logic [3:0]        pad;
        logic [BYTE_W-1:0] data_byte;
        logic [IDX_W-1:0]  node_right;
        logic [IDX_W-1:0]  node_left;
        logic [SYM_W-1:0]  node_value;
        logic              node_is_leaf;
        logic [IDX_W-1:0]  node_index;
    } s_word_t;

    localparam int S_TDATA_W = $bits(s_word_t);

    typedef logic [ADDR_W-1:0] addr_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic start;
        logic data;
        logic fetch;
        logic step;
        logic resolve;
        logic flush;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic stall;
        logic stop;
        logic pend_valid;
        logic out_free;
    } dp_status_t;

    function automatic addr_t node_addr(input logic [IDX_W-1:0] idx);
        logic [31:0] wide;
        wide = 32'(idx);
        return wide[ADDR_W-1:0];
    endfunction

    function automatic logic node_in_range(input logic [IDX_W-1:0] idx);
        return 32'(idx) < 32'(NODE_DEPTH);
    endfunction

endpackage

`default_nettype wire

// ===== hdl/htwd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module htwd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hdl/htwd_ctrl.sv =====
// Controller state machine: sequences fetch, bit walk, final resolve and flush.
`default_nettype none

module htwd_ctrl
    import htwd_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    input  wire logic [CMD_W-1:0] s_command,
    output logic                  s_tready,
    output dp_cmd_t               cmd,
    input  wire dp_status_t       status
);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_FETCH   = 3'd1;
    localparam logic [2:0] ST_WALK    = 3'd2;
    localparam logic [2:0] ST_RESOLVE = 3'd3;
    localparam logic [2:0] ST_FLUSH   = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [BIT_W-1:0] step_cnt_reg, step_cnt_next;
    logic             accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next    = state_reg;
        step_cnt_next = step_cnt_reg;
        cmd           = '0;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.load  = accept && (s_command == CMD_LOAD);
                cmd.start = accept && (s_command == CMD_START);
                cmd.data  = accept && (s_command == CMD_DATA);
                if (cmd.data) begin
                    state_next    = ST_FETCH;
                    step_cnt_next = '0;
                end
            end
            ST_FETCH: begin
                cmd.fetch  = 1'b1;
                state_next = ST_WALK;
            end
            ST_WALK: begin
                cmd.step = 1'b1;
                if (!status.stall) begin
                    if (status.stop) begin
                        state_next = ST_FLUSH;
                    end else if (step_cnt_reg == BIT_W'(BYTE_W - 1)) begin
                        state_next = ST_RESOLVE;
                    end else begin
                        step_cnt_next = step_cnt_reg + 1'b1;
                    end
                end
            end
            ST_RESOLVE: begin
                cmd.resolve = 1'b1;
                if (!status.stall) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                cmd.flush = 1'b1;
                if (!status.pend_valid || status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            step_cnt_reg <= '0;
        end else begin
            state_reg    <= state_next;
            step_cnt_reg <= step_cnt_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/htwd_dp.sv =====
// Datapath: node table, walk position, symbol count, held symbol and output register.
`default_nettype none

module htwd_dp
    import htwd_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire dp_cmd_t            cmd,
    output dp_status_t              status,
    input  wire s_word_t            s_word,
    input  wire logic               cfg_wr_en,
    input  wire logic [COUNT_W-1:0] cfg_wr_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [SYM_W-1:0]        m_symbol,
    output logic                    m_last,
    output logic                    m_done
);

    // Where the node under the walk comes from in the current cycle.
    localparam logic [1:0] SRC_FETCH = 2'd0;
    localparam logic [1:0] SRC_CHILD = 2'd1;
    localparam logic [1:0] SRC_ROOT  = 2'd2;

    logic [IDX_W-1:0]   current_reg, current_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [COUNT_W-1:0] symbol_count_reg, symbol_count_next;
    logic [BYTE_W-1:0]  byte_reg, byte_next;
    logic [IDX_W-1:0]   child_reg, child_next;
    logic [1:0]         src_reg, src_next;
    logic               rd_oob_reg, rd_oob_next;
    addr_t              last_addr_reg;
    node_t              root_reg, root_next;

    logic               pend_valid_reg, pend_valid_next;
    logic [SYM_W-1:0]   pend_symbol_reg, pend_symbol_next;
    logic               pend_done_reg, pend_done_next;

    logic               out_valid_reg, out_valid_next;
    logic [SYM_W-1:0]   out_symbol_reg, out_symbol_next;
    logic               out_last_reg, out_last_next;
    logic               out_done_reg, out_done_next;

    logic [NODE_W-1:0]  ram_rdata;
    node_t              ram_node;
    node_t              here;
    node_t              load_node;
    logic [IDX_W-1:0]   cur_after;
    logic [IDX_W-1:0]   child;
    logic [COUNT_W-1:0] count_after;
    logic               emit;
    logic               emit_req;
    logic               emit_ok;
    logic               walk_ok;
    logic               bit_go;
    logic               stop;
    logic               stall;
    logic               out_free;
    logic               flush_push;
    logic               ram_we;
    addr_t              raddr;

    assign load_node = '{leaf:  s_word.node_is_leaf,
                         value: s_word.node_value,
                         left:  s_word.node_left,
                         right: s_word.node_right};
    assign ram_we    = cmd.load && node_in_range(s_word.node_index);

    htwd_ram #(
        .WIDTH (NODE_W),
        .DEPTH (NODE_DEPTH)
    ) u_node_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (node_addr(s_word.node_index)),
        .wdata (load_node),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    // A child index past the table reads as an all-zero node.
    assign ram_node = rd_oob_reg ? node_t'('0) : node_t'(ram_rdata);

    // Settle the child read issued last cycle, then look at the current bit.
    always_comb begin
        emit      = 1'b0;
        here      = ram_node;
        cur_after = current_reg;
        unique case (src_reg)
            SRC_CHILD: begin
                if (ram_node.leaf) begin
                    emit      = 1'b1;
                    here      = root_reg;
                    cur_after = '0;
                end else begin
                    cur_after = child_reg;
                end
            end
            SRC_ROOT: begin
                here      = root_reg;
                cur_after = '0;
            end
            default: begin
                here      = ram_node;
                cur_after = current_reg;
            end
        endcase
    end

    assign out_free    = !out_valid_reg || m_ready;
    assign emit_req    = (cmd.step || cmd.resolve) && emit;
    assign count_after = count_reg + COUNT_W'(emit_req);
    assign stop        = count_after >= symbol_count_reg;
    assign stall       = emit_req && pend_valid_reg && !out_free;
    assign walk_ok     = (cmd.step || cmd.resolve) && !stall;
    assign bit_go      = cmd.step && !stop && !stall;
    assign emit_ok     = emit_req && !stall;
    assign child       = byte_reg[0] ? here.right : here.left;
    assign flush_push  = cmd.flush && pend_valid_reg && out_free;

    assign status = '{stall: stall, stop: stop, pend_valid: pend_valid_reg,
                      out_free: out_free};

    always_comb begin
        current_next      = current_reg;
        count_next        = count_reg;
        symbol_count_next = symbol_count_reg;
        byte_next         = byte_reg;
        child_next        = child_reg;
        src_next          = src_reg;
        rd_oob_next       = rd_oob_reg;
        raddr             = last_addr_reg;
        root_next         = root_reg;

        if (cfg_wr_en) begin
            symbol_count_next = cfg_wr_data;
        end
        if (cmd.load && (s_word.node_index == '0)) begin
            root_next = load_node;
        end
        if (cmd.start) begin
            current_next = '0;
            count_next   = '0;
        end
        if (cmd.data) begin
            byte_next = s_word.data_byte;
        end
        if (cmd.fetch) begin
            raddr       = node_addr(current_reg);
            rd_oob_next = !node_in_range(current_reg);
            src_next    = SRC_FETCH;
        end
        if (walk_ok) begin
            current_next = cur_after;
            count_next   = count_after;
            src_next     = SRC_ROOT;
            if (bit_go) begin
                byte_next = byte_reg >> 1;
                if (here.leaf) begin
                    current_next = '0;
                end else begin
                    raddr       = node_addr(child);
                    rd_oob_next = !node_in_range(child);
                    child_next  = child;
                    src_next    = SRC_CHILD;
                end
            end
        end
    end

    // A symbol waits in the hold register until the next one, or the end of
    // the byte, tells whether it is the byte's final symbol.
    always_comb begin
        pend_valid_next  = pend_valid_reg;
        pend_symbol_next = pend_symbol_reg;
        pend_done_next   = pend_done_reg;
        out_valid_next   = out_valid_reg;
        out_symbol_next  = out_symbol_reg;
        out_last_next    = out_last_reg;
        out_done_next    = out_done_reg;

        if (m_ready) begin
            out_valid_next = 1'b0;
        end
        if ((emit_ok && pend_valid_reg) || flush_push) begin
            out_valid_next  = 1'b1;
            out_symbol_next = pend_symbol_reg;
            out_done_next   = pend_done_reg;
            out_last_next   = flush_push;
        end
        if (emit_ok) begin
            pend_valid_next  = 1'b1;
            pend_symbol_next = ram_node.value;
            pend_done_next   = (count_after == symbol_count_reg);
        end else if (flush_push) begin
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            current_reg      <= '0;
            count_reg        <= '0;
            symbol_count_reg <= '0;
            src_reg          <= SRC_ROOT;
            pend_valid_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
        end else begin
            current_reg      <= current_next;
            count_reg        <= count_next;
            symbol_count_reg <= symbol_count_next;
            src_reg          <= src_next;
            pend_valid_reg   <= pend_valid_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg        <= byte_next;
        child_reg       <= child_next;
        rd_oob_reg      <= rd_oob_next;
        last_addr_reg   <= raddr;
        root_reg        <= root_next;
        pend_symbol_reg <= pend_symbol_next;
        pend_done_reg   <= pend_done_next;
        out_symbol_reg  <= out_symbol_next;
        out_last_reg    <= out_last_next;
        out_done_reg    <= out_done_next;
    end

    assign m_valid  = out_valid_reg;
    assign m_symbol = out_symbol_reg;
    assign m_last   = out_last_reg;
    assign m_done   = out_done_reg;

endmodule

`default_nettype wire

// ===== hdl/huffman_table_walk_decoder.sv =====
// Top level of the Huffman table-walk decoder: stream ports, controller and datapath.
`default_nettype none

// Huffman table-walk decoder. Input words come in three kinds, selected by
// s_tuser: a load word writes one node of the 512-entry node table (leaf flag,
// symbol, left and right child), a start word returns the walk to the root
// (node 0) and clears the symbol count, and a data word supplies eight coded
// bits that are walked least significant bit first, a 1 taking the right child
// and a 0 the left child. Each leaf reached produces one output word carrying
// the symbol; m_tlast marks the final symbol produced by a data word and
// m_tuser marks the symbol that brings the count to the configured
// symbol_count, after which all further bits are ignored until the next start.
// A data word passes through acceptance, a read of the node under the walk,
// a step per bit, and then settling of the last read and hand-over of the
// final symbol; it ends sooner once the symbol count is reached. The walk is
// paced by the node table's single read port with registered read data: each
// bit that moves the walk needs a table read that depends on the one before
// it. A symbol is held back one step so that its tlast can be known, and an
// output register lets the walk continue while the previous word waits on
// m_tready. Table entries must be written before the walk reads them.
// symbol_count is written through cfg_wr_en and cfg_wr_data; the user must do
// so only while the block is idle, and the block itself does not enforce it.

module huffman_table_walk_decoder
    import htwd_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // Input words.
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // node_index[8:0], node_is_leaf[9], node_value[17:10], node_left[26:18],
    // node_right[35:27], data_byte[43:36], zero fill [47:44].
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // command[1:0].
    input  wire logic [CMD_W-1:0]     s_tuser,
    // Decoded symbols.
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // symbol[7:0].
    output logic [SYM_W-1:0]          m_tdata,
    output logic                      m_tlast,
    // stream_done[0].
    output logic                      m_tuser,
    // symbol_count register.
    input  wire logic                 cfg_wr_en,
    input  wire logic [COUNT_W-1:0]   cfg_wr_data
);

    dp_cmd_t    cmd;
    dp_status_t status;
    s_word_t    s_word;

    assign s_word = s_word_t'(s_tdata);

    htwd_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_command (s_tuser),
        .s_tready  (s_tready),
        .cmd       (cmd),
        .status    (status)
    );

    htwd_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .s_word      (s_word),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_valid     (m_tvalid),
        .m_ready     (m_tready),
        .m_symbol    (m_tdata),
        .m_last      (m_tlast),
        .m_done      (m_tuser)
    );

endmodule

`default_nettype wire

// ===== bench/symbol_stream_check.sv =====
// Checker for the table-walk decoder: predicts the decoded symbol words and compares them.

module symbol_stream_check
    import htwd_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    input  wire logic                 s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire logic [CMD_W-1:0]     s_tuser,
    input  wire logic                 m_tvalid,
    input  wire logic                 m_tready,
    input  wire logic [SYM_W-1:0]     m_tdata,
    input  wire logic                 m_tlast,
    input  wire logic                 m_tuser,
    input  wire logic                 cfg_wr_en,
    input  wire logic [COUNT_W-1:0]   cfg_wr_data,
    output int                        failures,
    output int                        pending
);

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             last;
        logic             done;
    } symbol_word_t;

    // Private copy of the decoder state.
    node_t              node_table [NODE_DEPTH];
    logic [IDX_W-1:0]   walk_pos;
    logic [COUNT_W-1:0] decoded;
    logic [COUNT_W-1:0] count_limit;
    symbol_word_t       symbols_due [$];

    initial begin
        failures = 0;
        pending  = 0;
        foreach (node_table[i]) node_table[i] = '0;
    end

    // Walks the eight bits of one data word and queues every symbol it reaches.
    task automatic walk_byte(input logic [BYTE_W-1:0] bits);
        node_t            here;
        node_t            next_node;
        logic [IDX_W-1:0] next_idx;
        symbol_word_t     sym;
        int               first_new;
        first_new = symbols_due.size();
        for (int b = 0; b < BYTE_W; b++) begin
            if (decoded >= count_limit) break;
            here = node_table[walk_pos];
            if (here.leaf) begin
                // A leaf under the walk swallows the bit and returns to the root.
                walk_pos = '0;
                continue;
            end
            next_idx  = bits[b] ? here.right : here.left;
            next_node = node_table[next_idx];
            if (next_node.leaf) begin
                decoded    = decoded + 1;
                sym.symbol = next_node.value;
                sym.last   = 1'b0;
                sym.done   = (decoded == count_limit);
                symbols_due.push_back(sym);
                walk_pos = '0;
            end else begin
                walk_pos = next_idx;
            end
        end
        if (symbols_due.size() > first_new) begin
            sym = symbols_due.pop_back();
            sym.last = 1'b1;
            symbols_due.push_back(sym);
        end
    endtask

    always @(posedge aclk) begin : watch
        s_word_t      w;
        node_t        entry;
        symbol_word_t want;
        if (!aresetn) begin
            walk_pos    = '0;
            decoded     = '0;
            count_limit = '0;
            symbols_due.delete();
        end else begin
            if (cfg_wr_en) count_limit = cfg_wr_data;
            if (s_tvalid && s_tready) begin
                w = s_tdata;
                case (s_tuser)
                    CMD_LOAD: begin
                        entry.leaf  = w.node_is_leaf;
                        entry.value = w.node_value;
                        entry.left  = w.node_left;
                        entry.right = w.node_right;
                        node_table[w.node_index] = entry;
                    end
                    CMD_START: begin
                        walk_pos = '0;
                        decoded  = '0;
                    end
                    CMD_DATA: walk_byte(w.data_byte);
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (symbols_due.size() == 0) begin
                    $display("%0t: symbol word with none due: symbol %02h last %b done %b",
                             $time, m_tdata, m_tlast, m_tuser);
                    failures = failures + 1;
                end else begin
                    want = symbols_due.pop_front();
                    if (m_tdata !== want.symbol) begin
                        $display("%0t: symbol expected %02h, got %02h",
                                 $time, want.symbol, m_tdata);
                        failures = failures + 1;
                    end
                    if (m_tlast !== want.last) begin
                        $display("%0t: tlast expected %b, got %b", $time, want.last, m_tlast);
                        failures = failures + 1;
                    end
                    if (m_tuser !== want.done) begin
                        $display("%0t: stream_done expected %b, got %b",
                                 $time, want.done, m_tuser);
                        failures = failures + 1;
                    end
                end
            end
        end
        pending <= symbols_due.size();
    end

endmodule

// ===== bench/huffman_table_walk_decoder_test.sv =====
// Top of the table-walk decoder test: clock, reset, word stimulus, receiver and verdict.

module huffman_table_walk_decoder_test;
    import htwd_pkg::*;

    // Random words to send after the directed part.
    localparam int RANDOM_WORDS  = 285;
    // Extra wait after the output drains; this covers a data word that yields nothing.
    localparam int SETTLE_CYCLES = 32;
    // Length of the one long receiver hold-off, in cycles.
    localparam int LONG_HOLD     = 300;
    // Time limit for the whole run; reaching it reports a failure.
    localparam int RUN_LIMIT     = 6_000_000;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [CMD_W-1:0]     s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [SYM_W-1:0]     m_tdata;
    logic                 m_tlast;
    logic                 m_tuser;
    logic                 cfg_wr_en;
    logic [COUNT_W-1:0]   cfg_wr_data;

    int failures;
    int pending;

    // Stimulus controls. A quiet side runs with no idle cycles at all, and
    // hold_request asks the receiver for its one long hold-off.
    bit tx_quiet     = 1'b0;
    bit rx_quiet     = 1'b0;
    bit hold_request = 1'b0;

    // Table entries written so far. The walk may only ever reach these, so
    // every inner node that is loaded points at written entries (or itself).
    bit written [NODE_DEPTH];
    int written_list [$];
    int words_sent = 0;

    huffman_table_walk_decoder uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    symbol_stream_check symbol_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .failures    (failures),
        .pending     (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #(RUN_LIMIT);
        $display("FAIL huffman_table_walk_decoder");
        $finish;
    end

    // A word with every field random but the zero fill; the caller overwrites what matters.
    // Fields that the command does not use stay random so that they toggle too.
    function automatic s_word_t random_word();
        s_word_t w;
        w = S_TDATA_W'({$urandom(), $urandom()});
        w.pad = '0;
        return w;
    endfunction

    function automatic s_word_t node_word(input int idx, input bit leaf,
                                          input logic [SYM_W-1:0] value,
                                          input int left, input int right);
        s_word_t w;
        w = random_word();
        w.node_index   = IDX_W'(idx);
        w.node_is_leaf = leaf;
        w.node_value   = value;
        w.node_left    = IDX_W'(left);
        w.node_right   = IDX_W'(right);
        return w;
    endfunction

    // Offers one word after a random idle stretch and waits for the handshake.
    // tvalid is only lowered when a gap follows, so back-to-back words keep it high.
    task automatic send_word(input logic [CMD_W-1:0] kind, input s_word_t w);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= w;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic load_node(input s_word_t w);
        send_word(CMD_LOAD, w);
        if (!written[w.node_index]) begin
            written[w.node_index] = 1'b1;
            written_list.push_back(int'(w.node_index));
        end
        words_sent++;
    endtask

    task automatic send_start();
        send_word(CMD_START, random_word());
        words_sent++;
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] bits);
        s_word_t w;
        w = random_word();
        w.data_byte = bits;
        send_word(CMD_DATA, w);
        words_sent++;
    endtask

    // Command 3 is not defined; the block must drop it without effect.
    task automatic send_unused();
        send_word(CMD_W'(3), random_word());
    endtask

    // Stops offering words and waits until every predicted symbol has come out,
    // then a little longer for a data word that produces nothing.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Only called while the block is idle.
    task automatic set_symbol_count(input logic [COUNT_W-1:0] n);
        cfg_wr_data <= n;
        cfg_wr_en   <= 1'b1;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Child for a random inner node: any written entry, or the node itself.
    function automatic int safe_child(input int self_idx);
        int k;
        k = $urandom_range(0, written_list.size());
        return (k == written_list.size()) ? self_idx : written_list[k];
    endfunction

    // Loads a random full binary tree rooted at node 0 with the given number
    // of leaves, placed at random table indices so every index bit is used.
    task automatic build_tree(input int leaves);
        int slot_idx [20];
        int left_of [20];
        int right_of [20];
        int open_leaves [$];
        bit taken [NODE_DEPTH];
        int slots;
        int pick;
        int p;
        int n;
        bit is_leaf;
        s_word_t w;
        slot_idx[0] = 0;
        left_of[0]  = -1;
        taken[0]    = 1'b1;
        slots       = 1;
        open_leaves.push_back(0);
        // Split a random leaf into an inner node with two fresh leaves.
        while (open_leaves.size() < leaves) begin
            pick = $urandom_range(0, open_leaves.size() - 1);
            p = open_leaves[pick];
            open_leaves.delete(pick);
            for (int c = 0; c < 2; c++) begin
                do n = $urandom_range(1, NODE_DEPTH - 1); while (taken[n]);
                taken[n]        = 1'b1;
                slot_idx[slots] = n;
                left_of[slots]  = -1;
                if (c == 0) left_of[p] = slots;
                else right_of[p] = slots;
                open_leaves.push_back(slots);
                slots++;
            end
        end
        for (int s = 0; s < slots; s++) begin
            is_leaf = (left_of[s] < 0);
            w = node_word(slot_idx[s], is_leaf, SYM_W'($urandom_range(0, 255)),
                          $urandom_range(0, NODE_DEPTH - 1),
                          $urandom_range(0, NODE_DEPTH - 1));
            if (!is_leaf) begin
                w.node_left  = IDX_W'(slot_idx[left_of[s]]);
                w.node_right = IDX_W'(slot_idx[right_of[s]]);
            end
            load_node(w);
        end
    endtask

    // Occasional disturbance inside a stream: an undefined command, a stray
    // start, or a load that may rewrite the node under the walk.
    task automatic send_noise();
        int idx;
        case ($urandom_range(0, 2))
            0: send_unused();
            1: send_start();
            default: begin
                idx = $urandom_range(0, NODE_DEPTH - 1);
                load_node(node_word(idx, 1'($urandom_range(0, 1)),
                                    SYM_W'($urandom_range(0, 255)),
                                    safe_child(idx), safe_child(idx)));
            end
        endcase
    endtask

    // Receiver: a random hold-off before each word, none while quiet, and one
    // long hold-off on request so that the block backs up into its input.
    initial begin : receiver
        int wait_cycles;
        m_tready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else begin
                wait_cycles = rx_quiet ? 0 : $urandom_range(0, 12);
                if (wait_cycles > 0) begin
                    m_tready <= 1'b0;
                    repeat (wait_cycles) @(posedge aclk);
                end
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    initial begin : stimulus
        int phase;
        int random_start;
        int n_bytes;
        logic [COUNT_W-1:0] limit;

        aresetn     <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tuser     <= CMD_LOAD;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part. With no limit on the symbol count, a root that is a
        // leaf swallows every bit; this data word also comes before any start.
        set_symbol_count('1);
        load_node(node_word(0, 1'b1, 8'h5A, 0, 0));
        send_byte(8'hFF);

        // A small tree: root 0 -> left 256 (00), right 170; node 170 ->
        // left 511 (FF), right 85 (55).
        load_node(node_word(511, 1'b1, 8'hFF, 511, 511));
        load_node(node_word(256, 1'b1, 8'h00, 0, 0));
        load_node(node_word(85, 1'b1, 8'h55, 0, 0));
        load_node(node_word(170, 1'b0, 8'h00, 511, 85));
        load_node(node_word(0, 1'b0, 8'hFF, 256, 170));
        send_byte(8'h00);   // eight symbols from one word
        send_byte(8'h55);
        send_byte(8'hFF);
        // Seven symbols, then the walk is left standing on node 170.
        send_byte(8'h80);
        // Turning the node under the walk into a leaf: the next bit only
        // returns the walk to the root.
        load_node(node_word(170, 1'b1, 8'h77, 0, 0));
        send_byte(8'h00);
        load_node(node_word(170, 1'b0, 8'h00, 511, 85));
        send_unused();
        send_start();
        settle();

        // A stream of three symbols; the word after the end yields nothing.
        set_symbol_count(3);
        send_start();
        send_byte(8'h00);
        send_byte(8'h00);
        settle();

        // A symbol count of zero decodes nothing at all.
        set_symbol_count(0);
        send_start();
        send_byte(8'hFF);
        settle();

        // Lowering the count below what has already been decoded ends the stream.
        set_symbol_count(10);
        send_start();
        send_byte(8'h00);
        settle();
        set_symbol_count(5);
        send_byte(8'h00);
        settle();

        // Random part: one fresh tree per phase, a new symbol count, then a
        // stream of random data words with some disturbance mixed in.
        random_start = words_sent;
        phase = 0;
        while (words_sent - random_start < RANDOM_WORDS) begin
            tx_quiet = ($urandom_range(0, 4) == 0);
            rx_quiet = ($urandom_range(0, 4) == 0);
            build_tree($urandom_range(2, 9));
            settle();
            if (phase == 3) begin
                // The receiver stalls for a long stretch while words keep
                // coming back to back, then the sender waits for the backlog.
                set_symbol_count('1);
                tx_quiet = 1'b1;
                hold_request = 1'b1;
                send_start();
                repeat (16) send_byte(BYTE_W'($urandom_range(0, 255)));
                settle();
            end else begin
                case ($urandom_range(0, 7))
                    0: limit = '0;
                    1: limit = '1;
                    2: limit = $urandom();
                    default: limit = $urandom_range(1, 24);
                endcase
                set_symbol_count(limit);
                // Now and then the stream carries on without a fresh start.
                if ($urandom_range(0, 5) != 0) send_start();
                n_bytes = $urandom_range(1, 8);
                repeat (n_bytes) begin
                    if ($urandom_range(0, 9) == 0) send_noise();
                    send_byte(BYTE_W'($urandom_range(0, 255)));
                end
                settle();
            end
            phase++;
        end

        if (failures == 0) begin
            $display("PASS huffman_table_walk_decoder");
        end else begin
            $display("FAIL huffman_table_walk_decoder");
        end
        $finish;
    end

endmodule
